### hdl/tki_pkg.sv
// shared types, codes and constants for the transmit key interlock
`default_nettype none

package tki_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ARM    = 2'd1;
    localparam logic [1:0] REQ_PTT    = 2'd2;
    localparam logic [1:0] REQ_BUTTON = 2'd3;

    // event codes
    localparam logic [3:0] EV_NONE           = 4'd0;
    localparam logic [3:0] EV_KEYED          = 4'd1;
    localparam logic [3:0] EV_REF_UNARMED    = 4'd2;
    localparam logic [3:0] EV_REF_RADIO      = 4'd3;
    localparam logic [3:0] EV_REF_BATT       = 4'd4;
    localparam logic [3:0] EV_ARMED          = 4'd5;
    localparam logic [3:0] EV_DISARMED       = 4'd6;
    localparam logic [3:0] EV_UNKEY_HOST     = 4'd7;
    localparam logic [3:0] EV_UNKEY_BUTTON   = 4'd8;
    localparam logic [3:0] EV_UNKEY_MAXTIME  = 4'd9;
    localparam logic [3:0] EV_UNKEY_HOSTGONE = 4'd10;
    localparam logic [3:0] EV_EXPIRED        = 4'd11;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_MAGIC      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_LIFETIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE       = 3'd4;

    // configuration reset values
    localparam logic [31:0] ARM_LIFETIME_RST = 32'd600000;
    localparam logic [31:0] MAX_KEY_RST      = 32'd180000;
    localparam logic [12:0] BATTERY_MIN_RST  = 13'd3400;
    localparam logic [9:0]  DEBOUNCE_RST     = 10'd30;

    // stream widths
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic [31:0] arm_magic;
        logic [31:0] arm_lifetime_ms;
        logic [31:0] max_key_ms;
        logic [12:0] battery_min_mv;
        logic [9:0]  debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] arm_word;
        logic        ptt_request;
        logic        button_down;
        logic        host_present;
        logic        clip_tx_busy;
        logic        radio_ok;
        logic [12:0] battery_mv;
    } item_t;

    typedef struct packed {
        logic       ptt_active;
        logic       mic_from_host;
        logic       arm_active;
        logic [3:0] event_code;
    } result_t;

endpackage

`default_nettype wire

### hdl/tki_core.sv
// interlock state registers and the single-pass update for one request
`default_nettype none

module tki_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire tki_pkg::item_t   item,
    input  wire tki_pkg::cfg_t    cfg,
    output tki_pkg::result_t      result
);
    import tki_pkg::*;

    logic [31:0] time_now_reg,    time_now_next;
    logic [31:0] key_start_reg,   key_start_next;
    logic [31:0] arm_expiry_reg,  arm_expiry_next;
    logic [31:0] btn_change_reg,  btn_change_next;
    logic        armed_reg,       armed_next;
    logic        keyed_reg,       keyed_next;
    logic        route_reg,       route_next;
    logic        btn_level_reg,   btn_level_next;
    logic [3:0]  event_code;

    // tick path terms
    logic [31:0] time_inc;
    logic [31:0] key_elapsed;
    logic [31:0] expiry_diff;
    logic        max_hit;
    logic        keyed_after_max;
    logic        host_gone;
    logic        keyed_after_gone;
    logic        arm_expired;

    // key attempt terms
    logic        key_ok;
    logic [3:0]  key_event;

    // button debounce terms
    logic [31:0] btn_elapsed;
    logic        btn_change;

    assign time_inc         = time_now_reg + 32'd1;
    assign key_elapsed      = time_inc - key_start_reg;
    assign max_hit          = keyed_reg && (key_elapsed > cfg.max_key_ms);
    assign keyed_after_max  = keyed_reg && !max_hit;
    assign host_gone        = keyed_after_max && !item.host_present && !item.clip_tx_busy;
    assign keyed_after_gone = keyed_after_max && !host_gone;
    assign expiry_diff      = time_inc - arm_expiry_reg;
    assign arm_expired      = armed_reg && (expiry_diff != 32'd0) && !expiry_diff[31];

    // key refusal ladder, shared by host and button keying
    always_comb
    begin
        key_ok = 1'b0;
        if (keyed_reg)
            key_event = EV_NONE;
        else if (!armed_reg)
            key_event = EV_REF_UNARMED;
        else if (!item.radio_ok)
            key_event = EV_REF_RADIO;
        else if (item.battery_mv < cfg.battery_min_mv)
            key_event = EV_REF_BATT;
        else
        begin
            key_event = EV_KEYED;
            key_ok    = 1'b1;
        end
    end

    assign btn_elapsed = time_now_reg - btn_change_reg;
    assign btn_change  = (item.button_down != btn_level_reg)
                         && (btn_elapsed > {22'd0, cfg.debounce_ms});

    // next state and event for the current request
    always_comb
    begin
        time_now_next   = time_now_reg;
        key_start_next  = key_start_reg;
        arm_expiry_next = arm_expiry_reg;
        btn_change_next = btn_change_reg;
        armed_next      = armed_reg;
        keyed_next      = keyed_reg;
        route_next      = route_reg;
        btn_level_next  = btn_level_reg;
        event_code      = EV_NONE;
        unique case (item.req_type)
            REQ_TICK:
            begin
                time_now_next = time_inc;
                keyed_next    = keyed_after_gone && !arm_expired;
                route_next    = route_reg && keyed_after_gone && !arm_expired;
                if (arm_expired)
                    armed_next = 1'b0;
                if (max_hit)
                    event_code = EV_UNKEY_MAXTIME;
                else if (host_gone)
                    event_code = EV_UNKEY_HOSTGONE;
                else if (arm_expired)
                    event_code = EV_EXPIRED;
            end
            REQ_ARM:
            begin
                if (item.arm_word == cfg.arm_magic)
                begin
                    armed_next      = 1'b1;
                    arm_expiry_next = time_now_reg + cfg.arm_lifetime_ms;
                    event_code      = EV_ARMED;
                end
                else
                begin
                    armed_next = 1'b0;
                    keyed_next = 1'b0;
                    route_next = 1'b0;
                    event_code = EV_DISARMED;
                end
            end
            REQ_PTT:
            begin
                if (item.ptt_request)
                begin
                    event_code = key_event;
                    if (key_ok)
                    begin
                        keyed_next     = 1'b1;
                        route_next     = 1'b1;
                        key_start_next = time_now_reg;
                    end
                end
                else if (keyed_reg)
                begin
                    keyed_next = 1'b0;
                    route_next = 1'b0;
                    event_code = EV_UNKEY_HOST;
                end
            end
            REQ_BUTTON:
            begin
                if (btn_change)
                begin
                    btn_level_next  = item.button_down;
                    btn_change_next = time_now_reg;
                    if (item.button_down)
                    begin
                        event_code = key_event;
                        if (key_ok)
                        begin
                            keyed_next     = 1'b1;
                            route_next     = 1'b0;
                            key_start_next = time_now_reg;
                        end
                    end
                    else if (keyed_reg)
                    begin
                        keyed_next = 1'b0;
                        route_next = 1'b0;
                        event_code = EV_UNKEY_BUTTON;
                    end
                end
            end
            default:
            begin
                event_code = EV_NONE;
            end
        endcase
    end

    // result follows the updated state
    assign result.ptt_active    = keyed_next;
    assign result.mic_from_host = route_next;
    assign result.arm_active    = armed_next;
    assign result.event_code    = event_code;

    // state update on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg   <= '0;
            key_start_reg  <= '0;
            arm_expiry_reg <= '0;
            btn_change_reg <= '0;
            armed_reg      <= 1'b0;
            keyed_reg      <= 1'b0;
            route_reg      <= 1'b0;
            btn_level_reg  <= 1'b0;
        end
        else if (fire)
        begin
            time_now_reg   <= time_now_next;
            key_start_reg  <= key_start_next;
            arm_expiry_reg <= arm_expiry_next;
            btn_change_reg <= btn_change_next;
            armed_reg      <= armed_next;
            keyed_reg      <= keyed_next;
            route_reg      <= route_next;
            btn_level_reg  <= btn_level_next;
        end
    end

`ifndef SYNTH
    // the transmitter is never keyed without an arm
    a_keyed_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        keyed_reg |-> armed_reg)
        else $error("keyed while disarmed");

    // host audio route only while keyed
    a_route_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        route_reg |-> keyed_reg)
        else $error("host audio routed while unkeyed");

    // time only moves on an accepted request
    a_time_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(time_now_reg))
        else $error("time advanced without a request");
`endif

endmodule

`default_nettype wire

### hdl/tki_outq.sv
// two-entry result queue between the update stage and the output stream
`default_nettype none

module tki_outq
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tki_pkg::result_t   push_data,
    output logic                    not_full,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output tki_pkg::result_t        head
);
    import tki_pkg::*;

    result_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        pop;

    assign not_full = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

`ifndef SYNTH
    // never more than two results held
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue overflow");

    // a push only lands in a free slot
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full)
        else $error("push into full result queue");

    // a lone pop frees exactly one slot
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("fill count wrong after pop");
`endif

endmodule

`default_nettype wire

### hdl/transmit_key_interlock.sv
// transmit key interlock top level: stream ports, config registers, input stage
//
//  channel  | direction | handshake            | content
//  ---------+-----------+----------------------+-------------------------------
//  s_*      | in        | s_tvalid / s_tready  | one request per transfer
//  m_*      | out       | m_tvalid / m_tready  | one result per request
//  cfg_*    | in        | cfg_valid/cfg_ready  | register index and write data
//
// A request is taken every cycle while the result queue has room; it is
// captured in the input register, goes through the single-pass update and is
// written into the result queue, from which m_* offers it. The two-entry
// result queue lets requests keep flowing while a result waits. Reset clears
// all state and loads the configuration defaults. cfg_ready is always high.
`default_nettype none

module transmit_key_interlock
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // arm_word, ptt_request, button_down, host_present, clip_tx_busy,
    // radio_ok, battery_mv, zero fill
    input  wire logic [tki_pkg::IN_TDATA_W-1:0]    s_tdata,
    // req_type
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // ptt_active, mic_from_host, arm_active, event_code, zero fill
    output logic [tki_pkg::OUT_TDATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tki_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data
);
    import tki_pkg::*;

    cfg_t        cfg_reg;
    item_t       item_reg;
    logic        item_vld_reg;
    logic        q_not_full;
    logic        advance;
    result_t     core_result;
    result_t     q_head;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_magic       <= '0;
            cfg_reg.arm_lifetime_ms <= ARM_LIFETIME_RST;
            cfg_reg.max_key_ms      <= MAX_KEY_RST;
            cfg_reg.battery_min_mv  <= BATTERY_MIN_RST;
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ARM_MAGIC:    cfg_reg.arm_magic       <= cfg_data;
                CFG_ARM_LIFETIME: cfg_reg.arm_lifetime_ms <= cfg_data;
                CFG_MAX_KEY:      cfg_reg.max_key_ms      <= cfg_data;
                CFG_BATTERY_MIN:  cfg_reg.battery_min_mv  <= cfg_data[12:0];
                CFG_DEBOUNCE:     cfg_reg.debounce_ms     <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    // input stage: holds one request until the queue has room
    assign advance  = item_vld_reg && q_not_full;
    assign s_tready = !item_vld_reg || q_not_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (s_tready)
            item_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.req_type     <= s_tuser;
            item_reg.arm_word     <= s_tdata[31:0];
            item_reg.ptt_request  <= s_tdata[32];
            item_reg.button_down  <= s_tdata[33];
            item_reg.host_present <= s_tdata[34];
            item_reg.clip_tx_busy <= s_tdata[35];
            item_reg.radio_ok     <= s_tdata[36];
            item_reg.battery_mv   <= s_tdata[49:37];
        end
    end

    // interlock update
    tki_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // result queue
    tki_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (core_result),
        .not_full  (q_not_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head      (q_head)
    );

    assign m_tdata = {1'b0, q_head.event_code, q_head.arm_active,
                      q_head.mic_from_host, q_head.ptt_active};

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for the transmit key interlock: directed and random requests
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tki_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;
    localparam int REPORT_CAP  = 100;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]             s_tuser   = REQ_TICK;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_ARM_MAGIC;
    logic [31:0]            cfg_data  = '0;

    // requests waiting to go out and results still owed by the block
    item_t   pending_reqs[$];
    result_t due_results[$];
    item_t   next_req;
    item_t   seen_req;
    result_t want;
    logic    req_taken    = 1'b0;
    int      idle_odds    = 0;
    int      send_hold    = 0;
    int      recv_hold    = 0;
    int      quiet_cycles = 0;
    int      mismatches   = 0;

    // predicted interlock state and settings
    cfg_t        model_cfg;
    logic [31:0] now_ms;
    logic [31:0] key_on_ms;
    logic [31:0] arm_until_ms;
    logic [31:0] btn_changed_ms;
    logic        armed;
    logic        keyed;
    logic        route_host;
    logic        btn_level;

    transmit_key_interlock u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        if (mismatches < REPORT_CAP)
            $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // unkey if keyed; the reason only counts when something was dropped
    function automatic logic [3:0] drop_tx(logic [3:0] why);
        if (!keyed)
            return EV_NONE;
        keyed      = 1'b0;
        route_host = 1'b0;
        return why;
    endfunction

    // key request through the arm, radio and battery interlocks
    function automatic logic [3:0] key_tx(logic from_host, logic radio_up, logic [12:0] batt);
        if (keyed)
            return EV_NONE;
        if (!armed)
            return EV_REF_UNARMED;
        if (!radio_up)
            return EV_REF_RADIO;
        if (batt < model_cfg.battery_min_mv)
            return EV_REF_BATT;
        route_host = from_host;
        keyed      = 1'b1;
        key_on_ms  = now_ms;
        return EV_KEYED;
    endfunction

    // one request through the interlock, giving the drive levels and event
    function automatic result_t interlock_update(item_t r);
        logic [3:0]  ev;
        logic [3:0]  why;
        logic [31:0] past;
        result_t     res;
        ev = EV_NONE;
        case (r.req_type)
            REQ_TICK:
            begin
                now_ms = now_ms + 32'd1;
                past = now_ms - key_on_ms;
                if (keyed && past > model_cfg.max_key_ms)
                begin
                    why = drop_tx(EV_UNKEY_MAXTIME);
                    if (ev == EV_NONE)
                        ev = why;
                end
                if (keyed && !r.host_present && !r.clip_tx_busy)
                begin
                    why = drop_tx(EV_UNKEY_HOSTGONE);
                    if (ev == EV_NONE)
                        ev = why;
                end
                // expiry: now strictly past the deadline, signed 32-bit distance
                past = now_ms - arm_until_ms;
                if (armed && past != 32'd0 && !past[31])
                begin
                    void'(drop_tx(EV_EXPIRED));
                    armed = 1'b0;
                    if (ev == EV_NONE)
                        ev = EV_EXPIRED;
                end
            end
            REQ_ARM:
            begin
                if (r.arm_word == model_cfg.arm_magic)
                begin
                    armed        = 1'b1;
                    arm_until_ms = now_ms + model_cfg.arm_lifetime_ms;
                    ev           = EV_ARMED;
                end
                else
                begin
                    void'(drop_tx(EV_DISARMED));
                    armed = 1'b0;
                    ev    = EV_DISARMED;
                end
            end
            REQ_PTT:
            begin
                if (r.ptt_request)
                    ev = key_tx(1'b1, r.radio_ok, r.battery_mv);
                else
                    ev = drop_tx(EV_UNKEY_HOST);
            end
            default:
            begin
                // button: level change only after the debounce window
                past = now_ms - btn_changed_ms;
                if (r.button_down != btn_level && past > {22'd0, model_cfg.debounce_ms})
                begin
                    btn_level      = r.button_down;
                    btn_changed_ms = now_ms;
                    if (r.button_down)
                        ev = key_tx(1'b0, r.radio_ok, r.battery_mv);
                    else
                        ev = drop_tx(EV_UNKEY_BUTTON);
                end
            end
        endcase
        res = '{ptt_active: keyed, mic_from_host: route_host, arm_active: armed,
                event_code: ev};
        return res;
    endfunction

    // driver: request side and result backpressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                if (send_hold > 0)
                begin
                    send_hold <= send_hold - 1;
                    s_tvalid  <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req = pending_reqs.pop_front();
                    s_tdata  <= {6'd0, next_req.battery_mv, next_req.radio_ok,
                                 next_req.clip_tx_busy, next_req.host_present,
                                 next_req.button_down, next_req.ptt_request,
                                 next_req.arm_word};
                    s_tuser  <= next_req.req_type;
                    s_tvalid <= 1'b1;
                    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                        send_hold <= $urandom_range(1, 17);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            // result stalls in bursts
            if (recv_hold > 0)
            begin
                recv_hold <= recv_hold - 1;
                m_tready  <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                recv_hold <= $urandom_range(0, 16);
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: settings, predictions, result checks and watchdog on the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            model_cfg = '{arm_magic: 32'd0, arm_lifetime_ms: ARM_LIFETIME_RST,
                          max_key_ms: MAX_KEY_RST, battery_min_mv: BATTERY_MIN_RST,
                          debounce_ms: DEBOUNCE_RST};
            now_ms         = '0;
            key_on_ms      = '0;
            arm_until_ms   = '0;
            btn_changed_ms = '0;
            armed          = 1'b0;
            keyed          = 1'b0;
            route_host     = 1'b0;
            btn_level      = 1'b0;
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            req_taken <= s_tvalid && s_tready;

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ARM_MAGIC:    model_cfg.arm_magic       = cfg_data;
                    CFG_ARM_LIFETIME: model_cfg.arm_lifetime_ms = cfg_data;
                    CFG_MAX_KEY:      model_cfg.max_key_ms      = cfg_data;
                    CFG_BATTERY_MIN:  model_cfg.battery_min_mv  = cfg_data[12:0];
                    CFG_DEBOUNCE:     model_cfg.debounce_ms     = cfg_data[9:0];
                    default:          ;
                endcase
            end

            // result against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no request pending", m_tdata));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[0] !== want.ptt_active || m_tdata[1] !== want.mic_from_host ||
                        m_tdata[2] !== want.arm_active || m_tdata[6:3] !== want.event_code)
                        report_mismatch($sformatf(
                            "ptt %b/%b mic %b/%b arm %b/%b event %0d/%0d (got/expected)",
                            m_tdata[0], want.ptt_active, m_tdata[1], want.mic_from_host,
                            m_tdata[2], want.arm_active, m_tdata[6:3], want.event_code));
                end
            end

            // accepted request
            if (s_tvalid && s_tready)
            begin
                seen_req = '{req_type: s_tuser, arm_word: s_tdata[31:0],
                             ptt_request: s_tdata[32], button_down: s_tdata[33],
                             host_present: s_tdata[34], clip_tx_busy: s_tdata[35],
                             radio_ok: s_tdata[36], battery_mv: s_tdata[49:37]};
                due_results.push_back(interlock_update(seen_req));
            end

            // watchdog on cycles without any transfer
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(logic [31:0] magic, logic [31:0] life, logic [31:0] max_key,
                                 logic [12:0] batt_min, logic [9:0] debounce);
        write_reg(CFG_ARM_MAGIC, magic);
        write_reg(CFG_ARM_LIFETIME, life);
        write_reg(CFG_MAX_KEY, max_key);
        write_reg(CFG_BATTERY_MIN, {19'd0, batt_min});
        write_reg(CFG_DEBOUNCE, {22'd0, debounce});
    endtask

    task automatic add_req(logic [1:0] kind, logic [31:0] word, logic ptt, logic btn,
                           logic host, logic clip, logic radio, logic [12:0] batt);
        item_t r;
        r = '{req_type: kind, arm_word: word, ptt_request: ptt, button_down: btn,
              host_present: host, clip_tx_busy: clip, radio_ok: radio, battery_mv: batt};
        pending_reqs.push_back(r);
    endtask

    // mostly well-formed traffic: valid arms, keys that pass the battery floor, host present
    task automatic queue_random_reqs(int count);
        item_t r;
        int    pick;
        repeat (count)
        begin
            r.arm_word     = $urandom;
            r.ptt_request  = 1'($urandom_range(0, 1));
            r.button_down  = 1'($urandom_range(0, 1));
            r.host_present = ($urandom_range(0, 9) != 0);
            r.clip_tx_busy = 1'($urandom_range(0, 1));
            r.radio_ok     = ($urandom_range(0, 9) != 0);
            r.battery_mv   = 13'($urandom_range(0, 6000));
            if ($urandom_range(0, 6) != 0)
                r.battery_mv = 13'($urandom_range(6000, model_cfg.battery_min_mv));
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                r.req_type = REQ_TICK;
            end
            else if (pick < 52)
            begin
                r.req_type = REQ_ARM;
                if ($urandom_range(0, 4) != 0)
                    r.arm_word = model_cfg.arm_magic;
            end
            else if (pick < 77)
            begin
                r.req_type    = REQ_PTT;
                r.ptt_request = ($urandom_range(0, 9) < 6);
            end
            else
            begin
                r.req_type = REQ_BUTTON;
            end
            pending_reqs.push_back(r);
        end
    endtask

    // hold off until every request is out and every result is back
    task automatic wait_all_returned();
        while (pending_reqs.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge clk);
    endtask

    // test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: interlocks and host keying under reset settings
        idle_odds = 5;
        add_req(REQ_PTT,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 13'd6000);
        add_req(REQ_BUTTON, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 13'd6000);
        add_req(REQ_ARM,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_ARM,    32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_PTT,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 13'd6000);
        add_req(REQ_PTT,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 13'd3399);
        add_req(REQ_PTT,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 13'd3400);
        add_req(REQ_PTT,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 13'd3400);
        add_req(REQ_TICK,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 13'd3400);
        add_req(REQ_TICK,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 13'd3400);
        add_req(REQ_PTT,    32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd3400);
        add_req(REQ_PTT,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 13'd6000);
        add_req(REQ_ARM,    32'h1234_5678, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd6000);
        add_req(REQ_ARM,    32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd6000);
        add_req(REQ_PTT,    32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 13'd6000);
        add_req(REQ_PTT,    32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd6000);
        wait_all_returned();

        // directed: button keying, debounce, max key time and arm expiry
        load_settings(32'hFFFF_FFFF, 32'd5, 32'd3, 13'd0, 10'd0);
        add_req(REQ_ARM,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_BUTTON, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_TICK,   32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_BUTTON, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_BUTTON, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_TICK,   32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0);
        add_req(REQ_BUTTON, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 13'd0);
        repeat (4)
            add_req(REQ_TICK, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 13'd0);
        wait_all_returned();

        // random: short timers
        load_settings($urandom, $urandom_range(5, 60), $urandom_range(2, 30),
                      13'($urandom_range(0, 6000)), 10'($urandom_range(0, 8)));
        idle_odds = 6;
        queue_random_reqs(110);
        wait_all_returned();

        // random: lowest settings
        load_settings(32'h0000_0000, 32'd1, 32'd1, 13'd0, 10'd0);
        idle_odds = 3;
        queue_random_reqs(90);
        wait_all_returned();

        // random: longest timers and a high battery floor
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd6000, 10'd1000);
        idle_odds = 10;
        queue_random_reqs(70);
        wait_all_returned();

        load_settings($urandom, $urandom_range(5, 60), $urandom_range(2, 30),
                      13'($urandom_range(0, 6000)), 10'($urandom_range(0, 8)));
        idle_odds = 4;
        queue_random_reqs(110);
        wait_all_returned();

        // closing stretch at full rate
        load_settings($urandom, $urandom_range(5, 60), $urandom_range(2, 30),
                      13'($urandom_range(0, 6000)), 10'($urandom_range(0, 8)));
        idle_odds = 0;
        queue_random_reqs(100);
        wait_all_returned();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### transmit_key_interlock.f
hdl/tki_pkg.sv
hdl/tki_core.sv
hdl/tki_outq.sv
hdl/transmit_key_interlock.sv
dv/testbench.sv
